/* src/skc_pkg.sv */
`default_nettype none
package skc_pkg;

    localparam int MAX_QUERIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;

    localparam int KEY_W   = 16;
    localparam int INDEX_W = 6;
    localparam int GROUP_W = 7;

    typedef struct packed {
        logic [KEY_W-1:0] cluster_key;
        logic             last_query;
    } query_t;

    typedef struct packed {
        logic [INDEX_W-1:0] query_index;
        logic [KEY_W-1:0]   key_out;
        logic               new_group;
        logic [GROUP_W-1:0] groups_so_far;
        logic               dropped_flag;
        logic               last_result;
    } result_t;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/skc_cell.sv */
`default_nettype none
module skc_cell #(
    parameter int KEY_BITS = skc_pkg::KEY_BITS_DEF,
    parameter int IDX_W    = 6
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  skc_pkg::cell_ctrl_t     ctrl,
    input  wire [KEY_BITS-1:0]      new_key,
    input  wire [IDX_W-1:0]         new_idx,
    input  wire                     prev_le,
    input  wire                     prev_valid,
    input  wire [KEY_BITS-1:0]      prev_key,
    input  wire [IDX_W-1:0]         prev_idx,
    input  wire                     next_valid,
    input  wire [KEY_BITS-1:0]      next_key,
    input  wire [IDX_W-1:0]         next_idx,
    output logic                    le,
    output logic                    valid,
    output logic [KEY_BITS-1:0]     key,
    output logic [IDX_W-1:0]        idx
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // entries at or below the new key stay put, keeping ties in arrival order
    assign le = valid_reg && (key_reg <= new_key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        if (ctrl.ins && !le)
        begin
            if (prev_le)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                idx_next   = new_idx;
            end
            else
            begin
                valid_next = prev_valid;
                key_next   = prev_key;
                idx_next   = prev_idx;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            key_next   = next_key;
            idx_next   = next_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign idx   = idx_reg;

endmodule
`default_nettype wire

/* src/stable_key_sort_group_count.sv */
`default_nettype none
// Stable key sort with distinct-group count.
// Input: a query word (cluster_key, last_query) is taken at a clock edge where
// start is high and busy is low. Each word is numbered by its arrival position
// in the batch and slotted into a row of MAX_QUERIES cells kept in ascending
// key order, equal keys in arrival order. Loading takes one word per cycle
// while busy is low. A word with last_query set is stored too, then the row
// drains: busy rises, and the N result words (N = entries held) follow, one
// per cycle, each registered from the head cell of the row. Each result is
// shown on result for one cycle with strobe high; there is no back-pressure.
// busy falls during the cycle of the final result, so the next batch may start
// there. The drain rate is set by the row shifting one cell toward the head
// per cycle. Words that arrive with the row full are dropped and every result
// of that batch carries dropped_flag.
// Reset empties the row, clears the count and overflow flag, and drops strobe.
module stable_key_sort_group_count #(
    parameter int MAX_QUERIES = skc_pkg::MAX_QUERIES_DEF,
    parameter int KEY_BITS    = skc_pkg::KEY_BITS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  skc_pkg::query_t   query,
    output logic              busy,
    output logic              strobe,
    output skc_pkg::result_t  result
);

    localparam int IDX_W = $clog2(MAX_QUERIES);
    localparam int CNT_W = $clog2(MAX_QUERIES + 1);

    logic                         accept;
    logic                         room;
    logic [KEY_BITS-1:0]          in_key;
    skc_pkg::cell_ctrl_t          ctrl;

    logic [MAX_QUERIES-1:0]       c_le;
    logic [MAX_QUERIES-1:0]       c_valid;
    logic [KEY_BITS-1:0]          c_key [MAX_QUERIES];
    logic [IDX_W-1:0]             c_idx [MAX_QUERIES];

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         drain_reg, drain_next;
    logic [skc_pkg::GROUP_W-1:0]  grp_reg, grp_next;
    logic [KEY_BITS-1:0]          prev_key_reg, prev_key_next;
    logic                         strobe_reg, strobe_next;
    skc_pkg::result_t             result_reg, result_next;
    logic                         head_new;
    logic                         head_last;

    assign accept = start && !drain_reg;
    assign room   = count_reg < CNT_W'(MAX_QUERIES);
    assign in_key = KEY_BITS'(query.cluster_key);

    assign ctrl.ins   = accept && room;
    assign ctrl.shift = drain_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_QUERIES; g++)
        begin : g_cell
            logic                prev_le_w, prev_valid_w, next_valid_w;
            logic [KEY_BITS-1:0] prev_key_w, next_key_w;
            logic [IDX_W-1:0]    prev_idx_w, next_idx_w;

            if (g == 0)
            begin : g_head
                assign prev_le_w    = 1'b1;
                assign prev_valid_w = 1'b0;
                assign prev_key_w   = '0;
                assign prev_idx_w   = '0;
            end
            else
            begin : g_body
                assign prev_le_w    = c_le[g-1];
                assign prev_valid_w = c_valid[g-1];
                assign prev_key_w   = c_key[g-1];
                assign prev_idx_w   = c_idx[g-1];
            end

            if (g == MAX_QUERIES - 1)
            begin : g_tail
                assign next_valid_w = 1'b0;
                assign next_key_w   = '0;
                assign next_idx_w   = '0;
            end
            else
            begin : g_mid
                assign next_valid_w = c_valid[g+1];
                assign next_key_w   = c_key[g+1];
                assign next_idx_w   = c_idx[g+1];
            end

            skc_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_key    (in_key),
                .new_idx    (count_reg[IDX_W-1:0]),
                .prev_le    (prev_le_w),
                .prev_valid (prev_valid_w),
                .prev_key   (prev_key_w),
                .prev_idx   (prev_idx_w),
                .next_valid (next_valid_w),
                .next_key   (next_key_w),
                .next_idx   (next_idx_w),
                .le         (c_le[g]),
                .valid      (c_valid[g]),
                .key        (c_key[g]),
                .idx        (c_idx[g])
            );
        end
    endgenerate

    assign head_new  = (grp_reg == '0) || (c_key[0] != prev_key_reg);
    assign head_last = !c_valid[1];

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        drain_next    = drain_reg;
        grp_next      = grp_reg;
        prev_key_next = prev_key_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;

        if (accept)
        begin
            if (room)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (query.last_query)
            begin
                drain_next = 1'b1;
            end
        end

        if (drain_reg)
        begin
            strobe_next                = 1'b1;
            result_next.query_index    = skc_pkg::INDEX_W'(c_idx[0]);
            result_next.key_out        = skc_pkg::KEY_W'(c_key[0]);
            result_next.new_group      = head_new;
            result_next.groups_so_far  = skc_pkg::GROUP_W'(grp_reg + head_new);
            result_next.dropped_flag   = ovf_reg;
            result_next.last_result    = head_last;
            grp_next                   = skc_pkg::GROUP_W'(grp_reg + head_new);
            prev_key_next              = c_key[0];
            // final entry out: close the batch
            if (head_last)
            begin
                drain_next = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
                grp_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            grp_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            drain_reg  <= drain_next;
            grp_reg    <= grp_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_key_reg <= prev_key_next;
        result_reg   <= result_next;
    end

    assign busy   = drain_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* src/skc_checker.sv */
`default_nettype none
module skc_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               start,
    input skc_pkg::query_t   query,
    input wire               busy,
    input wire               strobe,
    input skc_pkg::result_t  result
);

    // the final result closes the batch, so the block is free again
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_result |-> !busy)
        else $error("busy still high on final result");

    // results of one batch come back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_result |=> strobe)
        else $error("gap inside a result burst");

    // group count advances exactly by the new-group flag
    a_group_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_result |=>
        result.groups_so_far ==
            skc_pkg::GROUP_W'($past(result.groups_so_far) + result.new_group))
        else $error("group count out of step");

    // a last word starts the drain
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && query.last_query |=> busy)
        else $error("drain did not start after last word");

endmodule

bind stable_key_sort_group_count skc_checker u_skc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .query  (query),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
`default_nettype wire
